// ===== design/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg: shared constants for the look-at view matrix block.
// Holds vector widths and the status and row codes used across the design.
// ----------------------------------------------------------------------------
package lav_pkg;

    // Width of a vector component fed to the normalizer. It covers both the
    // view difference (33 bits) and the up-axis candidate (under 2^33).
    localparam int VEC_W = 34;

    // Width of one coordinate at the block boundary.
    localparam int COORD_W = 32;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_DEGEN = 1'b1;

    // Row codes.
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_TRANS = 2'd3;

endpackage

// ===== design/lav_unit.sv =====
// ----------------------------------------------------------------------------
// lav_unit: pipelined vector normalizer.
// Scales a 3-vector into range, takes the floor square root of its squared
// length one bit per stage, then divides each component by that length one
// quotient bit per stage with round-to-nearest. A sideband rides along.
// ----------------------------------------------------------------------------
module lav_unit #(
    parameter int FB = 16,
    parameter int SW = 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [lav_pkg::VEC_W-1:0]        vec [3],
    input  logic [SW-1:0]                           side_in,
    input  logic [15:0]                             min_length,
    output logic                                    out_valid,
    output logic                                    out_ok,
    output logic signed [FB+1:0]                    n [3],
    output logic [SW-1:0]                           side_out
);

    localparam int VW_IN = lav_pkg::VEC_W;
    localparam int SMAX  = VW_IN - 30;
    localparam int SBW   = $clog2(SMAX + 1);
    localparam int NS    = 32;
    localparam int QW    = FB + 1;
    localparam int RW    = FB + 33;
    localparam int L     = NS + QW + 5;

    logic              vld_reg  [1:L];
    logic [SW-1:0]     side_reg [1:L];

    // Range reduction.
    logic [VW_IN-1:0]  a_mag [3];
    logic [VW_IN-1:0]  a_or;
    logic [SBW-1:0]    a_s;
    logic [29:0]       a_w_reg   [3];
    logic              a_neg_reg [3];
    logic              a_s0_reg;

    // Squares.
    logic [59:0]       b_sq_reg  [3];
    logic [29:0]       b_w_reg   [3];
    logic              b_neg_reg [3];
    logic              b_s0_reg;

    // Square root stages; index 0 holds the sum of squares.
    logic [62:0]       sqv_reg [0:NS];
    logic [62:0]       sqr_reg [0:NS];
    logic [29:0]       sqw_reg [0:NS][3];
    logic              sqn_reg [0:NS][3];
    logic              sqs_reg [0:NS];
    logic [62:0]       sq_t    [0:NS-1];
    logic [62:0]       sqv_next [0:NS-1];
    logic [62:0]       sqr_next [0:NS-1];

    // Divider stages; index 0 holds the rounded numerators.
    logic [30:0]       d_len;
    logic [RW-1:0]     dvr_reg [0:QW][3];
    logic [QW-1:0]     dvq_reg [0:QW][3];
    logic              dvn_reg [0:QW][3];
    logic [30:0]       dvd_reg [0:QW];
    logic              dvo_reg [0:QW];
    logic [RW-1:0]     dv_sh   [0:QW-1];
    logic [RW-1:0]     dvr_next [0:QW-1][3];
    logic [QW-1:0]     dvq_next [0:QW-1][3];

    logic signed [FB+1:0] n_reg [3];
    logic                 ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= L; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= L; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_in;
            for (int i = 2; i <= L; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // The shift count follows the highest set bit of any magnitude, so the
    // OR of the magnitudes is enough to find it.
    always_comb
    begin
        a_or = '0;
        for (int c = 0; c < 3; c++)
        begin
            a_mag[c] = vec[c][VW_IN-1] ? VW_IN'(-vec[c]) : VW_IN'(vec[c]);
            a_or     = a_or | a_mag[c];
        end
        a_s = '0;
        for (int k = 1; k <= SMAX; k++)
        begin
            if (a_or[29+k])
            begin
                a_s = SBW'(k);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            sq_t[k] = sqr_reg[k] + (63'(1) << (62 - 2*k));
            if (sqv_reg[k] >= sq_t[k])
            begin
                sqv_next[k] = sqv_reg[k] - sq_t[k];
                sqr_next[k] = (sqr_reg[k] >> 1) + (63'(1) << (62 - 2*k));
            end
            else
            begin
                sqv_next[k] = sqv_reg[k];
                sqr_next[k] = sqr_reg[k] >> 1;
            end
        end
    end

    assign d_len = sqr_reg[NS][30:0];

    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            dv_sh[j] = RW'(dvd_reg[j]) << (QW - 1 - j);
            for (int c = 0; c < 3; c++)
            begin
                if (dvr_reg[j][c] >= dv_sh[j])
                begin
                    dvr_next[j][c] = dvr_reg[j][c] - dv_sh[j];
                    dvq_next[j][c] = (dvq_reg[j][c] << 1) | QW'(1);
                end
                else
                begin
                    dvr_next[j][c] = dvr_reg[j][c];
                    dvq_next[j][c] = dvq_reg[j][c] << 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_w_reg[c]   <= 30'(a_mag[c] >> a_s);
                a_neg_reg[c] <= vec[c][VW_IN-1];
                b_sq_reg[c]  <= 60'(a_w_reg[c]) * 60'(a_w_reg[c]);
                b_w_reg[c]   <= a_w_reg[c];
                b_neg_reg[c] <= a_neg_reg[c];
                sqw_reg[0][c] <= b_w_reg[c];
                sqn_reg[0][c] <= b_neg_reg[c];
            end
            a_s0_reg   <= (a_s == '0);
            b_s0_reg   <= a_s0_reg;
            sqv_reg[0] <= 63'(b_sq_reg[0]) + 63'(b_sq_reg[1]) + 63'(b_sq_reg[2]);
            sqr_reg[0] <= '0;
            sqs_reg[0] <= b_s0_reg;

            for (int k = 0; k < NS; k++)
            begin
                sqv_reg[k+1] <= sqv_next[k];
                sqr_reg[k+1] <= sqr_next[k];
                sqs_reg[k+1] <= sqs_reg[k];
                for (int c = 0; c < 3; c++)
                begin
                    sqw_reg[k+1][c] <= sqw_reg[k][c];
                    sqn_reg[k+1][c] <= sqn_reg[k][c];
                end
            end

            // A length of zero is always degenerate; the threshold applies
            // only when no range reduction took place.
            dvd_reg[0] <= d_len;
            dvo_reg[0] <= (d_len != '0) && !(sqs_reg[NS] && (d_len < 31'(min_length)));
            for (int c = 0; c < 3; c++)
            begin
                dvr_reg[0][c] <= (RW'(sqw_reg[NS][c]) << FB) + RW'(d_len >> 1);
                dvq_reg[0][c] <= '0;
                dvn_reg[0][c] <= sqn_reg[NS][c];
            end

            for (int j = 0; j < QW; j++)
            begin
                dvd_reg[j+1] <= dvd_reg[j];
                dvo_reg[j+1] <= dvo_reg[j];
                for (int c = 0; c < 3; c++)
                begin
                    dvr_reg[j+1][c] <= dvr_next[j][c];
                    dvq_reg[j+1][c] <= dvq_next[j][c];
                    dvn_reg[j+1][c] <= dvn_reg[j][c];
                end
            end

            for (int c = 0; c < 3; c++)
            begin
                n_reg[c] <= dvn_reg[QW][c] ? -$signed((FB+2)'(dvq_reg[QW][c]))
                                           : $signed((FB+2)'(dvq_reg[QW][c]));
            end
            ok_reg <= dvo_reg[QW];
        end
    end

    assign out_valid = vld_reg[L];
    assign side_out  = side_reg[L];
    assign out_ok    = ok_reg;
    assign n         = n_reg;

endmodule

// ===== design/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix: left-handed look-at view matrix in signed fixed point.
// The request passes through two chained normalizers, each with a
// bit-per-stage square root and divider. A request can enter every cycle
// while in_ready is high; each one yields four rows (one on error), and the
// row sequencer holds the pipeline back while it plays them out.
// Reset clears all valid bits and sets min_length to 1.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] world_up_x,
    input  logic signed [31:0] world_up_y,
    input  logic signed [31:0] world_up_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row_index,
    output logic signed [31:0] elem_right,
    output logic signed [31:0] elem_up,
    output logic signed [31:0] elem_view,
    output logic               status,
    output logic               last
);

    localparam int FB    = FRACTION_BITS;
    localparam int CW    = lav_pkg::COORD_W;
    localparam int VW_IN = lav_pkg::VEC_W;
    localparam int VW    = FB + 2;        // unit vector component
    localparam int XW    = FB + 3;        // right axis component
    localparam int PW    = CW + VW;       // world up times view
    localparam int DPW   = VW_IN + VW;    // projection times view
    localparam int CPW   = 2 * VW;        // cross product term
    localparam int TPW   = CW + XW;       // eye times axis
    localparam int SIDEV = 6 * CW;

    // Rounding right shift by the fraction width, ties away from zero.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] q;
        m = x[63] ? 64'(-x) : 64'(x);
        q = (m + (64'(1) << (FB - 1))) >> FB;
        return x[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(x);
    endfunction

    logic [15:0] min_length_reg;

    // The whole pipeline moves together. It advances whenever the last stage
    // is empty or the row sequencer is free to take its contents.
    logic adv;
    logic take;

    logic signed [31:0] eye_a [3];
    logic signed [31:0] tgt_a [3];
    logic signed [31:0] wup_a [3];

    assign eye_a[0] = eye_x;
    assign eye_a[1] = eye_y;
    assign eye_a[2] = eye_z;
    assign tgt_a[0] = target_x;
    assign tgt_a[1] = target_y;
    assign tgt_a[2] = target_z;
    assign wup_a[0] = world_up_x;
    assign wup_a[1] = world_up_y;
    assign wup_a[2] = world_up_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= 16'd1;
        else if (cfg_we)
            min_length_reg <= cfg_wdata;
    end

    // ------------------------------------------------------------------
    // Stage 0: register the request and form the view difference.
    // ------------------------------------------------------------------
    logic                    p0_v_reg;
    logic signed [31:0]      p0_eye_reg [3];
    logic signed [31:0]      p0_wup_reg [3];
    logic signed [VW_IN-1:0] p0_dv_reg  [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_eye_reg[i] <= eye_a[i];
                p0_wup_reg[i] <= wup_a[i];
                p0_dv_reg[i]  <= VW_IN'(tgt_a[i]) - VW_IN'(eye_a[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // View normalizer. Eye and world up ride in the sideband.
    // ------------------------------------------------------------------
    logic              uv_valid;
    logic              uv_ok;
    logic signed [VW-1:0] uv_n [3];
    logic [SIDEV-1:0]  uv_side;
    logic signed [31:0] uv_eye [3];
    logic signed [31:0] uv_wup [3];

    lav_unit #(
        .FB (FB),
        .SW (SIDEV)
    ) u_view (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (p0_v_reg),
        .vec        (p0_dv_reg),
        .side_in    ({p0_eye_reg[0], p0_eye_reg[1], p0_eye_reg[2],
                      p0_wup_reg[0], p0_wup_reg[1], p0_wup_reg[2]}),
        .min_length (min_length_reg),
        .out_valid  (uv_valid),
        .out_ok     (uv_ok),
        .n          (uv_n),
        .side_out   (uv_side)
    );

    assign uv_eye[0] = uv_side[6*CW-1 -: CW];
    assign uv_eye[1] = uv_side[5*CW-1 -: CW];
    assign uv_eye[2] = uv_side[4*CW-1 -: CW];
    assign uv_wup[0] = uv_side[3*CW-1 -: CW];
    assign uv_wup[1] = uv_side[2*CW-1 -: CW];
    assign uv_wup[2] = uv_side[CW-1:0];

    // ------------------------------------------------------------------
    // Stages 1-4: project the view axis out of three up candidates: the
    // world up vector, then the Y axis and the Z axis as fallbacks. For
    // the unit axes the projection is just the matching view component.
    // ------------------------------------------------------------------
    logic                    m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg;
    logic                    m1_ok_reg, m2_ok_reg, m3_ok_reg, m4_ok_reg;
    logic signed [31:0]      m1_eye_reg [3], m2_eye_reg [3], m3_eye_reg [3], m4_eye_reg [3];
    logic signed [31:0]      m1_wup_reg [3], m2_wup_reg [3], m3_wup_reg [3];
    logic signed [VW-1:0]    m1_view_reg [3], m2_view_reg [3], m3_view_reg [3];
    logic signed [VW-1:0]    m4_view_reg [3];
    logic signed [PW-1:0]    m1_pw_reg [3];
    logic signed [VW_IN-1:0] m2_d_reg [3];
    logic signed [DPW-1:0]   m3_p_reg [3][3];
    logic signed [VW_IN-1:0] m4_u_reg [3][3];
    logic signed [VW_IN-1:0] cand [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cand[0][i] = VW_IN'(m3_wup_reg[i]);
            cand[1][i] = (i == 1) ? (VW_IN'(1) <<< FB) : '0;
            cand[2][i] = (i == 2) ? (VW_IN'(1) <<< FB) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_ok_reg <= uv_ok;
            m2_ok_reg <= m1_ok_reg;
            m3_ok_reg <= m2_ok_reg;
            m4_ok_reg <= m3_ok_reg;
            for (int i = 0; i < 3; i++)
            begin
                m1_eye_reg[i]  <= uv_eye[i];
                m1_wup_reg[i]  <= uv_wup[i];
                m1_view_reg[i] <= uv_n[i];
                m1_pw_reg[i]   <= PW'(uv_wup[i]) * PW'(uv_n[i]);

                m2_eye_reg[i]  <= m1_eye_reg[i];
                m2_wup_reg[i]  <= m1_wup_reg[i];
                m2_view_reg[i] <= m1_view_reg[i];

                m3_eye_reg[i]  <= m2_eye_reg[i];
                m3_wup_reg[i]  <= m2_wup_reg[i];
                m3_view_reg[i] <= m2_view_reg[i];

                m4_eye_reg[i]  <= m3_eye_reg[i];
                m4_view_reg[i] <= m3_view_reg[i];
            end
            m2_d_reg[0] <= VW_IN'(rshr(64'(m1_pw_reg[0]) + 64'(m1_pw_reg[1])
                                       + 64'(m1_pw_reg[2])));
            m2_d_reg[1] <= VW_IN'(m1_view_reg[1]);
            m2_d_reg[2] <= VW_IN'(m1_view_reg[2]);
            for (int l = 0; l < 3; l++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m3_p_reg[l][i] <= DPW'(m2_d_reg[l]) * DPW'(m2_view_reg[i]);
                    m4_u_reg[l][i] <= cand[l][i] - VW_IN'(rshr(64'(m3_p_reg[l][i])));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_v_reg <= in_valid;
            m1_v_reg <= uv_valid;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Three up normalizers in parallel. The sideband is split across the
    // lanes: eye on the first, view on the second, view status on the third.
    // ------------------------------------------------------------------
    logic                 u0_valid, u1_valid, u2_valid;
    logic                 u0_ok, u1_ok, u2_ok;
    logic signed [VW-1:0] u0_n [3], u1_n [3], u2_n [3];
    logic [SIDEV/2-1:0]   u0_side;
    logic [3*VW-1:0]      u1_side;
    logic                 u2_side;

    lav_unit #(
        .FB (FB),
        .SW (SIDEV/2)
    ) u_up0 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (m4_v_reg),
        .vec        (m4_u_reg[0]),
        .side_in    ({m4_eye_reg[0], m4_eye_reg[1], m4_eye_reg[2]}),
        .min_length (min_length_reg),
        .out_valid  (u0_valid),
        .out_ok     (u0_ok),
        .n          (u0_n),
        .side_out   (u0_side)
    );

    lav_unit #(
        .FB (FB),
        .SW (3*VW)
    ) u_up1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (m4_v_reg),
        .vec        (m4_u_reg[1]),
        .side_in    ({m4_view_reg[0], m4_view_reg[1], m4_view_reg[2]}),
        .min_length (min_length_reg),
        .out_valid  (u1_valid),
        .out_ok     (u1_ok),
        .n          (u1_n),
        .side_out   (u1_side)
    );

    lav_unit #(
        .FB (FB),
        .SW (1)
    ) u_up2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (m4_v_reg),
        .vec        (m4_u_reg[2]),
        .side_in    (m4_ok_reg),
        .min_length (min_length_reg),
        .out_valid  (u2_valid),
        .out_ok     (u2_ok),
        .n          (u2_n),
        .side_out   (u2_side)
    );

    logic signed [31:0]   ul_eye  [3];
    logic signed [VW-1:0] ul_view [3];
    logic signed [VW-1:0] ul_up   [3];

    assign ul_eye[0]  = u0_side[3*CW-1 -: CW];
    assign ul_eye[1]  = u0_side[2*CW-1 -: CW];
    assign ul_eye[2]  = u0_side[CW-1:0];
    assign ul_view[0] = u1_side[3*VW-1 -: VW];
    assign ul_view[1] = u1_side[2*VW-1 -: VW];
    assign ul_view[2] = u1_side[VW-1:0];

    // The first candidate that is long enough wins.
    always_comb
    begin
        priority if (u0_ok)
            ul_up = u0_n;
        else if (u1_ok)
            ul_up = u1_n;
        else
            ul_up = u2_n;
    end

    // ------------------------------------------------------------------
    // Stages 5-9: select up, cross product for right, then translation.
    // ------------------------------------------------------------------
    logic                 s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg;
    logic                 s5_ok_reg, s6_ok_reg, s7_ok_reg, s8_ok_reg, s9_ok_reg;
    logic signed [31:0]   s5_eye_reg [3], s6_eye_reg [3], s7_eye_reg [3];
    logic signed [VW-1:0] s5_up_reg [3], s6_up_reg [3], s7_up_reg [3], s8_up_reg [3];
    logic signed [VW-1:0] s5_view_reg [3], s6_view_reg [3], s7_view_reg [3];
    logic signed [VW-1:0] s8_view_reg [3];
    logic signed [CPW-1:0] s6_ca_reg [3], s6_cb_reg [3];
    logic signed [XW-1:0] s7_right_reg [3], s8_right_reg [3];
    logic signed [TPW-1:0] s8_tp_reg [3][3];
    logic signed [31:0]   s9_r_reg [3], s9_u_reg [3], s9_w_reg [3], s9_tr_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ok_reg <= u2_side && (u0_ok || u1_ok || u2_ok);
            s6_ok_reg <= s5_ok_reg;
            s7_ok_reg <= s6_ok_reg;
            s8_ok_reg <= s7_ok_reg;
            s9_ok_reg <= s8_ok_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_eye_reg[i]  <= ul_eye[i];
                s5_up_reg[i]   <= ul_up[i];
                s5_view_reg[i] <= ul_view[i];
                s6_eye_reg[i]  <= s5_eye_reg[i];
                s6_up_reg[i]   <= s5_up_reg[i];
                s6_view_reg[i] <= s5_view_reg[i];
                s7_eye_reg[i]  <= s6_eye_reg[i];
                s7_up_reg[i]   <= s6_up_reg[i];
                s7_view_reg[i] <= s6_view_reg[i];
                s8_up_reg[i]   <= s7_up_reg[i];
                s8_view_reg[i] <= s7_view_reg[i];
                s8_right_reg[i] <= s7_right_reg[i];
                s7_right_reg[i] <= XW'(rshr(64'(s6_ca_reg[i]) - 64'(s6_cb_reg[i])));
                s8_tp_reg[0][i] <= TPW'(s7_eye_reg[i]) * TPW'(s7_right_reg[i]);
                s8_tp_reg[1][i] <= TPW'(s7_eye_reg[i]) * TPW'(s7_up_reg[i]);
                s8_tp_reg[2][i] <= TPW'(s7_eye_reg[i]) * TPW'(s7_view_reg[i]);
                s9_r_reg[i] <= sat32(64'(s8_right_reg[i]));
                s9_u_reg[i] <= sat32(64'(s8_up_reg[i]));
                s9_w_reg[i] <= sat32(64'(s8_view_reg[i]));
                s9_tr_reg[i] <= sat32(-rshr(64'(s8_tp_reg[i][0]) + 64'(s8_tp_reg[i][1])
                                            + 64'(s8_tp_reg[i][2])));
            end
            // right = up x view
            s6_ca_reg[0] <= CPW'(s5_up_reg[1]) * CPW'(s5_view_reg[2]);
            s6_cb_reg[0] <= CPW'(s5_up_reg[2]) * CPW'(s5_view_reg[1]);
            s6_ca_reg[1] <= CPW'(s5_up_reg[2]) * CPW'(s5_view_reg[0]);
            s6_cb_reg[1] <= CPW'(s5_up_reg[0]) * CPW'(s5_view_reg[2]);
            s6_ca_reg[2] <= CPW'(s5_up_reg[0]) * CPW'(s5_view_reg[1]);
            s6_cb_reg[2] <= CPW'(s5_up_reg[1]) * CPW'(s5_view_reg[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            s9_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_v_reg <= u0_valid;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            s9_v_reg <= s8_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Row sequencer. It holds one finished matrix and plays out its rows;
    // a degenerate request plays out a single zero row with error status.
    // The next matrix is taken in the cycle the last row leaves.
    // ------------------------------------------------------------------
    logic               ov_reg;
    logic [1:0]         row_reg;
    logic               err_reg;
    logic signed [31:0] buf_r_reg [4];
    logic signed [31:0] buf_u_reg [4];
    logic signed [31:0] buf_w_reg [4];
    logic               row_last;

    assign row_last = err_reg || (row_reg == lav_pkg::ROW_TRANS);
    assign take     = !ov_reg || (out_ready && row_last);
    assign adv      = !s9_v_reg || take;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            row_reg <= lav_pkg::ROW_FIRST;
            err_reg <= lav_pkg::STATUS_OK;
        end
        else if (ov_reg && out_ready && !row_last)
        begin
            row_reg <= row_reg + 2'd1;
        end
        else if (take)
        begin
            ov_reg  <= s9_v_reg;
            row_reg <= lav_pkg::ROW_FIRST;
            err_reg <= s9_ok_reg ? lav_pkg::STATUS_OK : lav_pkg::STATUS_DEGEN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s9_v_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                buf_r_reg[i] <= s9_ok_reg ? s9_r_reg[i] : '0;
                buf_u_reg[i] <= s9_ok_reg ? s9_u_reg[i] : '0;
                buf_w_reg[i] <= s9_ok_reg ? s9_w_reg[i] : '0;
            end
            buf_r_reg[3] <= s9_tr_reg[0];
            buf_u_reg[3] <= s9_tr_reg[1];
            buf_w_reg[3] <= s9_tr_reg[2];
        end
    end

    assign out_valid  = ov_reg;
    assign row_index  = row_reg;
    assign elem_right = buf_r_reg[row_reg];
    assign elem_up    = buf_u_reg[row_reg];
    assign elem_view  = buf_w_reg[row_reg];
    assign status     = err_reg;
    assign last       = row_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The three up normalizers run in lock step.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (u0_valid == u1_valid) && (u0_valid == u2_valid))
        else $error("up normalizer lanes out of step");

    // An error result is a single first row.
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lav_pkg::STATUS_DEGEN)
        |-> last && (row_index == lav_pkg::ROW_FIRST))
        else $error("error result is not a single first row");

    // Rows of one matrix follow in order without a gap in the valid.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> out_valid && (row_index == 2'($past(row_index) + 2'd1)))
        else $error("matrix rows out of order");

endmodule
